// ===== rtl/aspm_pkg.sv =====
// ----------------------------------------------------------------------------
// aspm_pkg
// Shared widths, constants and controller/datapath interface types for the
// analog stick to pointer motion core.
// ----------------------------------------------------------------------------
package aspm_pkg;

    localparam int SAMPLE_W   = 16;                 // stick and pointer fields
    localparam int DZ_W       = 15;                 // dead zone register
    localparam int MAG_W      = 24;                 // sqrt result, Q16.8
    localparam int MOP_B_W    = 16;                 // multiplier B operand
    localparam int PROD_W     = MAG_W + MOP_B_W;    // multiplier product
    localparam int SQ_W       = 32;                 // x^2 + y^2
    localparam int RAD_W      = SQ_W + 16;          // radicand, sum of squares << 16
    localparam int SREM_W     = MAG_W + 2;          // sqrt partial remainder
    localparam int DEN_W      = PROD_W;             // divisor
    localparam int QUO_W      = 31;                 // quotient, below 2^31
    localparam int NSR_W      = QUO_W;              // low numerator bits fed to divider
    localparam int COMP_W     = QUO_W + 1;          // signed scaled component
    localparam int SUM_W      = COMP_W + 1;         // accumulator plus component
    localparam int SLOW_BITS  = 11;                 // divide by 2048
    localparam int ACC_W      = SLOW_BITS + 1;      // signed sub-pixel remainder
    localparam int STEP_W     = 6;
    localparam int STEP_MAX   = 2**(STEP_W-1) - 1;
    localparam int CNT_W      = 5;
    localparam int SQRT_STEPS = MAG_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int FRAC_BITS  = 8;                  // fraction bits of the magnitude
    localparam int NUM_SHIFT  = 15;                 // numerator times full scale

    localparam logic [DZ_W-1:0]    DEAD_ZONE_RESET = 15'd3000;
    localparam logic [MOP_B_W-1:0] FULL_SCALE      = 16'd32768;

    // register index decoded from paddr[2]
    localparam logic REG_DEAD_ZONE = 1'b0;

    typedef enum logic [2:0] {
        MUL_SQX  = 3'd0,
        MUL_SQY  = 3'd1,
        MUL_DEN  = 3'd2,
        MUL_NUMX = 3'd3,
        MUL_NUMY = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sq_store;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     den_store;
        logic     div_init;
        logic     div_step;
        logic     cx_store;
        logic     cy_store;
        logic     comp_clear;
        logic     acc_sum;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic dead;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/aspm_ctrl.sv =====
// ----------------------------------------------------------------------------
// aspm_ctrl
// Sequencer for one item: squares, square root, dead zone check, two divides
// (skipped inside the dead zone), accumulation and result write.
// ----------------------------------------------------------------------------
module aspm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  aspm_pkg::dp_sts_t sts,
    output aspm_pkg::dp_cmd_t cmd
);

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_SQX  = 13'b0000000000010,
        ST_SQY  = 13'b0000000000100,
        ST_SUM  = 13'b0000000001000,
        ST_SQRT = 13'b0000000010000,
        ST_CHK  = 13'b0000000100000,
        ST_DEN  = 13'b0000001000000,
        ST_NUMX = 13'b0000010000000,
        ST_DIVX = 13'b0000100000000,
        ST_NUMY = 13'b0001000000000,
        ST_DIVY = 13'b0010000000000,
        ST_CY   = 13'b0100000000000,
        ST_ACC  = 13'b1000000000000
    } state_t;

    // result write shares the idle-return path; see ST_ACC handling below
    state_t                         state_reg, state_next;
    logic [aspm_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           out_pend_reg, out_pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            out_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            out_pend_reg <= out_pend_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !out_pend_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        out_pend_next = out_pend_reg;
        cmd           = '0;
        cmd.mul_sel   = aspm_pkg::MUL_SQX;

        case (state_reg)
            ST_IDLE: begin
                // out_pend: accumulated sums wait for the output register
                if (out_pend_reg) begin
                    if (sts.out_free) begin
                        cmd.out_load  = 1'b1;
                        out_pend_next = 1'b0;
                    end
                end else if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQX;
                end
            end
            ST_SQX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = aspm_pkg::MUL_SQX;
                state_next  = ST_SQY;
            end
            ST_SQY: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = aspm_pkg::MUL_SQY;
                cmd.sq_store = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == aspm_pkg::CNT_W'(aspm_pkg::SQRT_STEPS - 1)) begin
                    state_next = ST_CHK;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CHK: begin
                if (sts.dead) begin
                    cmd.comp_clear = 1'b1;
                    state_next     = ST_ACC;
                end else begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = aspm_pkg::MUL_DEN;
                    state_next  = ST_DEN;
                end
            end
            ST_DEN: begin
                cmd.den_store = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = aspm_pkg::MUL_NUMX;
                state_next    = ST_NUMX;
            end
            ST_NUMX: begin
                cmd.div_init = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = aspm_pkg::MUL_NUMY;
                cnt_next     = '0;
                state_next   = ST_DIVX;
            end
            ST_DIVX: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == aspm_pkg::CNT_W'(aspm_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_NUMY;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_NUMY: begin
                cmd.cx_store = 1'b1;
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVY;
            end
            ST_DIVY: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == aspm_pkg::CNT_W'(aspm_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_CY;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CY: begin
                cmd.cy_store = 1'b1;
                state_next   = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_sum   = 1'b1;
                out_pend_next = 1'b1;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/aspm_datapath.sv =====
// ----------------------------------------------------------------------------
// aspm_datapath
// Shared 24x16 multiplier, digit-serial square root, restoring divider,
// sub-pixel accumulators and the result register.
// ----------------------------------------------------------------------------
module aspm_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  aspm_pkg::dp_cmd_t                      cmd,
    output aspm_pkg::dp_sts_t                      sts,
    input  logic [aspm_pkg::DZ_W-1:0]              dead_zone,
    input  logic signed [aspm_pkg::SAMPLE_W-1:0]   s_stick_x,
    input  logic signed [aspm_pkg::SAMPLE_W-1:0]   s_stick_y,
    input  logic signed [aspm_pkg::SAMPLE_W-1:0]   s_pointer_x,
    input  logic signed [aspm_pkg::SAMPLE_W-1:0]   s_pointer_y,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [aspm_pkg::SAMPLE_W-1:0]   m_new_x,
    output logic signed [aspm_pkg::SAMPLE_W-1:0]   m_new_y,
    output logic signed [aspm_pkg::STEP_W-1:0]     m_step_x,
    output logic signed [aspm_pkg::STEP_W-1:0]     m_step_y
);

    typedef struct packed {
        logic signed [aspm_pkg::ACC_W-1:0]    acc;
        logic signed [aspm_pkg::STEP_W-1:0]   step;
        logic signed [aspm_pkg::SAMPLE_W-1:0] pos;
        logic                                 nz;
    } axis_res_t;

    // truncating divide by 2^SLOW_BITS, step and position saturation
    function automatic axis_res_t split_sum(
        input logic signed [aspm_pkg::SUM_W-1:0]    s,
        input logic signed [aspm_pkg::SAMPLE_W-1:0] p
    );
        logic                                          neg;
        logic [aspm_pkg::SUM_W-1:0]                    mag_s;
        logic [aspm_pkg::SUM_W-aspm_pkg::SLOW_BITS-1:0] qa;
        logic [aspm_pkg::SLOW_BITS-1:0]                ra;
        logic [aspm_pkg::STEP_W-1:0]                   ql;
        logic signed [aspm_pkg::STEP_W-1:0]            st;
        logic signed [aspm_pkg::SAMPLE_W:0]            np;
        axis_res_t                                     r;
        neg   = s[aspm_pkg::SUM_W-1];
        mag_s = neg ? aspm_pkg::SUM_W'(-s) : aspm_pkg::SUM_W'(s);
        qa    = mag_s[aspm_pkg::SUM_W-1:aspm_pkg::SLOW_BITS];
        ra    = mag_s[aspm_pkg::SLOW_BITS-1:0];
        ql    = qa[aspm_pkg::STEP_W-1:0];
        if (neg) begin
            if (qa > aspm_pkg::STEP_MAX + 1) begin
                st = $signed(aspm_pkg::STEP_W'(aspm_pkg::STEP_MAX + 1));
            end else begin
                st = $signed(aspm_pkg::STEP_W'(~ql + 1'b1));
            end
            r.acc = $signed(aspm_pkg::ACC_W'(~{1'b0, ra} + 1'b1));
        end else begin
            if (qa > aspm_pkg::STEP_MAX) begin
                st = $signed(aspm_pkg::STEP_W'(aspm_pkg::STEP_MAX));
            end else begin
                st = $signed(ql);
            end
            r.acc = $signed({1'b0, ra});
        end
        np = {p[aspm_pkg::SAMPLE_W-1], p}
           + {{(aspm_pkg::SAMPLE_W + 1 - aspm_pkg::STEP_W){st[aspm_pkg::STEP_W-1]}}, st};
        if (np[aspm_pkg::SAMPLE_W] != np[aspm_pkg::SAMPLE_W-1]) begin
            r.pos = np[aspm_pkg::SAMPLE_W] ? {1'b1, {(aspm_pkg::SAMPLE_W-1){1'b0}}}
                                           : {1'b0, {(aspm_pkg::SAMPLE_W-1){1'b1}}};
        end else begin
            r.pos = np[aspm_pkg::SAMPLE_W-1:0];
        end
        r.step = st;
        r.nz   = (qa != '0);
        return r;
    endfunction

    // captured item
    logic signed [aspm_pkg::SAMPLE_W-1:0] px_reg, py_reg;
    logic                                 negx_reg, negy_reg;
    logic [aspm_pkg::SAMPLE_W-1:0]        ax_reg, ay_reg;

    // multiplier
    logic [aspm_pkg::MAG_W-1:0]    mul_a;
    logic [aspm_pkg::MOP_B_W-1:0]  mul_b;
    logic [aspm_pkg::PROD_W-1:0]   prod_reg;
    logic [aspm_pkg::SQ_W-1:0]     sq_reg;
    logic [aspm_pkg::MOP_B_W-1:0]  dfs;
    logic [aspm_pkg::MAG_W-1:0]    dz_mag;
    logic [aspm_pkg::MAG_W-1:0]    mag_diff;

    // square root
    logic [aspm_pkg::RAD_W-1:0]    rad_reg;
    logic [aspm_pkg::SREM_W-1:0]   srem_reg;
    logic [aspm_pkg::MAG_W-1:0]    root_reg;
    logic [aspm_pkg::SREM_W+1:0]   srem_t;
    logic [aspm_pkg::SREM_W+1:0]   strial;
    logic                          sqrt_ge;

    // divider
    logic [aspm_pkg::DEN_W-1:0]    den_reg;
    logic [aspm_pkg::DEN_W-1:0]    drem_reg;
    logic [aspm_pkg::NSR_W-1:0]    nsr_reg;
    logic [aspm_pkg::QUO_W-1:0]    quot_reg;
    logic [aspm_pkg::DEN_W:0]      drem_t;
    logic                          div_ge;
    logic signed [aspm_pkg::COMP_W-1:0] comp_next;

    // accumulation and result
    logic signed [aspm_pkg::COMP_W-1:0] cx_reg, cy_reg;
    logic signed [aspm_pkg::SUM_W-1:0]  sumx_reg, sumy_reg;
    logic signed [aspm_pkg::ACC_W-1:0]  accx_reg, accy_reg;
    axis_res_t                          resx, resy;
    logic                               m_valid_reg, m_valid_next;
    logic signed [aspm_pkg::SAMPLE_W-1:0] new_x_reg, new_y_reg;
    logic signed [aspm_pkg::STEP_W-1:0]   step_x_reg, step_y_reg;

    assign dfs      = aspm_pkg::FULL_SCALE - {1'b0, dead_zone};
    assign dz_mag   = {1'b0, dead_zone, {aspm_pkg::FRAC_BITS{1'b0}}};
    assign mag_diff = root_reg - dz_mag;

    always_comb begin
        case (cmd.mul_sel)
            aspm_pkg::MUL_SQX: begin
                mul_a = aspm_pkg::MAG_W'(ax_reg);
                mul_b = ax_reg;
            end
            aspm_pkg::MUL_SQY: begin
                mul_a = aspm_pkg::MAG_W'(ay_reg);
                mul_b = ay_reg;
            end
            aspm_pkg::MUL_DEN: begin
                mul_a = root_reg;
                mul_b = dfs;
            end
            aspm_pkg::MUL_NUMX: begin
                mul_a = mag_diff;
                mul_b = ax_reg;
            end
            aspm_pkg::MUL_NUMY: begin
                mul_a = mag_diff;
                mul_b = ay_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one result bit per step: bring down two radicand bits, try 4r+1
    assign srem_t  = {srem_reg, rad_reg[aspm_pkg::RAD_W-1 -: 2]};
    assign strial  = {2'b00, root_reg, 2'b01};
    assign sqrt_ge = (srem_t >= strial);

    assign drem_t  = {drem_reg, nsr_reg[aspm_pkg::NSR_W-1]};
    assign div_ge  = (drem_t >= {1'b0, den_reg});

    assign comp_next = {1'b0, quot_reg};

    assign sts.dead     = (root_reg == '0) || (root_reg < dz_mag);
    assign sts.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg   <= s_pointer_x;
            py_reg   <= s_pointer_y;
            negx_reg <= s_stick_x[aspm_pkg::SAMPLE_W-1];
            negy_reg <= s_stick_y[aspm_pkg::SAMPLE_W-1];
            ax_reg   <= s_stick_x[aspm_pkg::SAMPLE_W-1] ? aspm_pkg::SAMPLE_W'(-s_stick_x)
                                                        : s_stick_x;
            ay_reg   <= s_stick_y[aspm_pkg::SAMPLE_W-1] ? aspm_pkg::SAMPLE_W'(-s_stick_y)
                                                        : s_stick_y;
        end
        if (cmd.mul_en) begin
            prod_reg <= aspm_pkg::PROD_W'(mul_a) * aspm_pkg::PROD_W'(mul_b);
        end
        if (cmd.sq_store) begin
            sq_reg <= prod_reg[aspm_pkg::SQ_W-1:0];
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= {sq_reg + prod_reg[aspm_pkg::SQ_W-1:0], 16'h0000};
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg  <= {rad_reg[aspm_pkg::RAD_W-3:0], 2'b00};
            srem_reg <= sqrt_ge ? aspm_pkg::SREM_W'(srem_t - strial)
                                : aspm_pkg::SREM_W'(srem_t);
            root_reg <= {root_reg[aspm_pkg::MAG_W-2:0], sqrt_ge};
        end
        if (cmd.den_store) begin
            den_reg <= prod_reg;
        end
        // numerator = product << 15; quotient fits 31 bits, so the top part
        // already lies below the divisor
        if (cmd.div_init) begin
            drem_reg <= aspm_pkg::DEN_W'(prod_reg[aspm_pkg::PROD_W-1:
                                                  aspm_pkg::NSR_W - aspm_pkg::NUM_SHIFT]);
            nsr_reg  <= {prod_reg[aspm_pkg::NSR_W-aspm_pkg::NUM_SHIFT-1:0],
                         {aspm_pkg::NUM_SHIFT{1'b0}}};
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            drem_reg <= div_ge ? aspm_pkg::DEN_W'(drem_t - {1'b0, den_reg})
                               : aspm_pkg::DEN_W'(drem_t);
            nsr_reg  <= {nsr_reg[aspm_pkg::NSR_W-2:0], 1'b0};
            quot_reg <= {quot_reg[aspm_pkg::QUO_W-2:0], div_ge};
        end
        if (cmd.comp_clear) begin
            cx_reg <= '0;
        end else if (cmd.cx_store) begin
            cx_reg <= negx_reg ? -comp_next : comp_next;
        end
        if (cmd.comp_clear) begin
            cy_reg <= '0;
        end else if (cmd.cy_store) begin
            cy_reg <= negy_reg ? -comp_next : comp_next;
        end
        if (cmd.acc_sum) begin
            sumx_reg <= aspm_pkg::SUM_W'(accx_reg) + aspm_pkg::SUM_W'(cx_reg);
            sumy_reg <= aspm_pkg::SUM_W'(accy_reg) + aspm_pkg::SUM_W'(cy_reg);
        end
        if (cmd.out_load) begin
            new_x_reg  <= resx.pos;
            new_y_reg  <= resy.pos;
            step_x_reg <= resx.step;
            step_y_reg <= resy.step;
        end
    end

    assign resx = split_sum(sumx_reg, px_reg);
    assign resy = split_sum(sumy_reg, py_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = resx.nz || resy.nz;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            accx_reg    <= '0;
            accy_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.out_load) begin
                accx_reg <= resx.acc;
                accy_reg <= resy.acc;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_new_x  = new_x_reg;
    assign m_new_y  = new_y_reg;
    assign m_step_x = step_x_reg;
    assign m_step_y = step_y_reg;

endmodule

// ===== rtl/analog_stick_to_pointer_motion_core.sv =====
// ----------------------------------------------------------------------------
// analog_stick_to_pointer_motion_core
// Radial rescaled dead zone on a stick sample, sub-pixel accumulation and
// saturated pointer update.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one stick sample pair plus the current pointer
//   position per transaction. Output channel m_*: new pointer position and
//   whole-pixel step; a transaction is produced only when a step is nonzero.
//   APB port: register 0 (byte address 0) holds the 15-bit dead zone.
// Sequencing:
//   One item at a time. The sequencer runs an item to the accumulated sums,
//   then loads the result register once it is free; the next item is
//   accepted in the cycle after that load. Inside the dead zone the two
//   divides are skipped. The time is set by the bit-serial square root
//   (24 steps) and two 31-step restoring divides that share one multiplier
//   and one divider.
// Reset:
//   Synchronous, active low. Clears the accumulators and the result valid,
//   and sets the dead zone to 3000.
// Stall:
//   A finished item waits in the sequencer until the result register is
//   free; no input is taken meanwhile.
// ----------------------------------------------------------------------------
module analog_stick_to_pointer_motion_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [aspm_pkg::SAMPLE_W-1:0] s_stick_x,
    input  logic signed [aspm_pkg::SAMPLE_W-1:0] s_stick_y,
    input  logic signed [aspm_pkg::SAMPLE_W-1:0] s_pointer_x,
    input  logic signed [aspm_pkg::SAMPLE_W-1:0] s_pointer_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [aspm_pkg::SAMPLE_W-1:0] m_new_x,
    output logic signed [aspm_pkg::SAMPLE_W-1:0] m_new_y,
    output logic signed [aspm_pkg::STEP_W-1:0]   m_step_x,
    output logic signed [aspm_pkg::STEP_W-1:0]   m_step_y,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [aspm_pkg::PADDR_W-1:0]         paddr,
    input  logic [aspm_pkg::PDATA_W-1:0]         pwdata,
    output logic [aspm_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    aspm_pkg::dp_cmd_t              cmd;
    aspm_pkg::dp_sts_t              sts;
    logic [aspm_pkg::DZ_W-1:0]      dead_zone_reg;
    logic                           reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == aspm_pkg::REG_DEAD_ZONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg <= aspm_pkg::DEAD_ZONE_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            dead_zone_reg <= pwdata[aspm_pkg::DZ_W-1:0];
        end
    end

    assign prdata = reg_sel ? aspm_pkg::PDATA_W'(dead_zone_reg) : '0;

    aspm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    aspm_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .dead_zone   (dead_zone_reg),
        .s_stick_x   (s_stick_x),
        .s_stick_y   (s_stick_y),
        .s_pointer_x (s_pointer_x),
        .s_pointer_y (s_pointer_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_x     (m_new_x),
        .m_new_y     (m_new_y),
        .m_step_x    (m_step_x),
        .m_step_y    (m_step_y)
    );

endmodule

// ===== rtl/aspm_checker.sv =====
// ----------------------------------------------------------------------------
// aspm_checker
// Port-level checks for the analog stick to pointer motion core.
// ----------------------------------------------------------------------------
module aspm_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [aspm_pkg::SAMPLE_W-1:0] m_new_x,
    input logic signed [aspm_pkg::SAMPLE_W-1:0] m_new_y,
    input logic signed [aspm_pkg::STEP_W-1:0]   m_step_x,
    input logic signed [aspm_pkg::STEP_W-1:0]   m_step_y
);

    // result held until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_x) && $stable(m_new_y)
                                && $stable(m_step_x) && $stable(m_step_y))
        else $error("result changed or dropped while stalled");

    // only moves are reported
    a_step_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_step_x != '0) || (m_step_y != '0))
        else $error("result transaction with zero step");

    // one item in flight: no acceptance right after one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

    // reset leaves no result and the input open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind analog_stick_to_pointer_motion_core aspm_checker u_aspm_checker (.*);

// ===== tb/analog_stick_to_pointer_motion_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// analog_stick_to_pointer_motion_core_tb
// Self-checking bench: stick samples go in through the s_ channel, and a
// scoreboard predicts the dead zone scaling, sub-pixel accumulation and
// saturated pointer update of each one. Every m_ transaction is checked
// against the oldest prediction. The dead zone register is reprogrammed
// over APB between phases, and the handshakes are throttled at random.
// ----------------------------------------------------------------------------
module analog_stick_to_pointer_motion_core_tb;

    localparam logic [aspm_pkg::PADDR_W-1:0] ADDR_DEAD_ZONE = 3'd0;
    localparam logic [aspm_pkg::PADDR_W-1:0] ADDR_SPARE     = 3'd4;   // no register here
    localparam int SETTLE_CYCLES = 120;
    localparam int DRAIN_LIMIT   = 5000;

    typedef struct {
        logic signed [aspm_pkg::SAMPLE_W-1:0] pos_x;
        logic signed [aspm_pkg::SAMPLE_W-1:0] pos_y;
        logic signed [aspm_pkg::STEP_W-1:0]   step_x;
        logic signed [aspm_pkg::STEP_W-1:0]   step_y;
    } pointer_move_t;

    class motion_scoreboard;
        localparam longint unsigned SPAN     = 32768;
        localparam longint          SLOWDOWN = 2048;

        logic [aspm_pkg::DZ_W-1:0] dead_zone;
        longint                    acc_x;
        longint                    acc_y;
        pointer_move_t             pending[$];
        int                        errors;

        function new();
            dead_zone = aspm_pkg::DEAD_ZONE_RESET;
            acc_x     = 0;
            acc_y     = 0;
            errors    = 0;
        endfunction

        static function longint clamp(longint v, longint lo, longint hi);
            return (v > hi) ? hi : ((v < lo) ? lo : v);
        endfunction

        // floor square root, one result bit per pass
        static function longint unsigned floor_root(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 23; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        static function longint scaled_component(
            logic signed [aspm_pkg::SAMPLE_W-1:0] c,
            longint unsigned mag,
            longint unsigned dz);
            longint unsigned a;
            longint unsigned q;
            a = (c < 0) ? longint'(-longint'(c)) : longint'(c);
            q = (a * SPAN * (mag - dz * 256)) / (mag * (SPAN - dz));
            return (c < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void set_reg(logic [aspm_pkg::PADDR_W-1:0] addr,
                              logic [aspm_pkg::PDATA_W-1:0] data);
            if (addr[2] == aspm_pkg::REG_DEAD_ZONE) dead_zone = data[aspm_pkg::DZ_W-1:0];
        endfunction

        function void note_input(logic signed [aspm_pkg::SAMPLE_W-1:0] sx, sy, px, py);
            longint          sq;
            longint unsigned mag;
            longint unsigned dz;
            longint          cx;
            longint          cy;
            longint          qx;
            longint          qy;
            pointer_move_t   mv;
            dz = dead_zone;
            cx = 0;
            cy = 0;
            sq  = longint'(sx) * longint'(sx) + longint'(sy) * longint'(sy);
            mag = floor_root(longint'(sq) << 16);
            if (dz < SPAN && mag != 0 && mag >= dz * 256) begin
                cx = scaled_component(sx, mag, dz);
                cy = scaled_component(sy, mag, dz);
            end
            // division truncates toward zero, remainder keeps the sign
            qx    = (acc_x + cx) / SLOWDOWN;
            qy    = (acc_y + cy) / SLOWDOWN;
            acc_x = (acc_x + cx) % SLOWDOWN;
            acc_y = (acc_y + cy) % SLOWDOWN;
            if (qx == 0 && qy == 0) return;
            mv.step_x = aspm_pkg::STEP_W'(clamp(qx, -32, 31));
            mv.step_y = aspm_pkg::STEP_W'(clamp(qy, -32, 31));
            mv.pos_x  = aspm_pkg::SAMPLE_W'(clamp(longint'(px) + mv.step_x, -32768, 32767));
            mv.pos_y  = aspm_pkg::SAMPLE_W'(clamp(longint'(py) + mv.step_y, -32768, 32767));
            pending.push_back(mv);
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic signed [aspm_pkg::SAMPLE_W-1:0] nx, ny,
                                   logic signed [aspm_pkg::STEP_W-1:0] stx, sty);
            pointer_move_t mv;
            if (pending.size() == 0) begin
                $display("%0t: unexpected transaction, actual new %0d,%0d step %0d,%0d",
                         $time, nx, ny, stx, sty);
                errors++;
                return;
            end
            mv = pending.pop_front();
            check_field("new_x", mv.pos_x, nx);
            check_field("new_y", mv.pos_y, ny);
            check_field("step_x", mv.step_x, stx);
            check_field("step_y", mv.step_y, sty);
        endfunction
    endclass

    logic                                   aclk        = 1'b0;
    logic                                   aresetn     = 1'b0;
    logic                                   s_valid     = 1'b0;
    logic                                   s_ready;
    logic signed [aspm_pkg::SAMPLE_W-1:0]   s_stick_x   = '0;
    logic signed [aspm_pkg::SAMPLE_W-1:0]   s_stick_y   = '0;
    logic signed [aspm_pkg::SAMPLE_W-1:0]   s_pointer_x = '0;
    logic signed [aspm_pkg::SAMPLE_W-1:0]   s_pointer_y = '0;
    logic                                   m_valid;
    logic                                   m_ready     = 1'b0;
    logic signed [aspm_pkg::SAMPLE_W-1:0]   m_new_x;
    logic signed [aspm_pkg::SAMPLE_W-1:0]   m_new_y;
    logic signed [aspm_pkg::STEP_W-1:0]     m_step_x;
    logic signed [aspm_pkg::STEP_W-1:0]     m_step_y;
    logic                                   psel        = 1'b0;
    logic                                   penable     = 1'b0;
    logic                                   pwrite      = 1'b0;
    logic [aspm_pkg::PADDR_W-1:0]           paddr       = '0;
    logic [aspm_pkg::PDATA_W-1:0]           pwdata      = '0;
    logic [aspm_pkg::PDATA_W-1:0]           prdata;
    logic                                   pready;

    int send_idle_pct = 10;
    int recv_idle_pct = 64;

    motion_scoreboard sb = new();

    analog_stick_to_pointer_motion_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_stick_x   (s_stick_x),
        .s_stick_y   (s_stick_y),
        .s_pointer_x (s_pointer_x),
        .s_pointer_y (s_pointer_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_x     (m_new_x),
        .m_new_y     (m_new_y),
        .m_step_x    (m_step_x),
        .m_step_y    (m_step_y),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_stick_x, s_stick_y, s_pointer_x, s_pointer_y);
            if (m_valid && m_ready)
                sb.check_result(m_new_x, m_new_y, m_step_x, m_step_y);
        end
    end

    task automatic send_item(logic signed [aspm_pkg::SAMPLE_W-1:0] sx, sy, px, py);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_stick_x   <= sx;
        s_stick_y   <= sy;
        s_pointer_x <= px;
        s_pointer_y <= py;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic apb_write(logic [aspm_pkg::PADDR_W-1:0] addr,
                             logic [aspm_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(addr, data);
    endtask

    task automatic check_dead_zone_readback();
        logic [aspm_pkg::PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_DEAD_ZONE;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        got = prdata;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== aspm_pkg::PDATA_W'(sb.dead_zone)) begin
            $display("%0t: dead_zone readback mismatch, expected %0d, actual %0d",
                     $time, sb.dead_zone, got);
            sb.errors++;
        end
    endtask

    // blocks until every predicted move has come out, then lets any
    // move-less item still in the pipe finish
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (sb.pending.size() != 0) begin
            $display("%0t: %0d expected transactions never arrived",
                     $time, sb.pending.size());
            sb.errors += sb.pending.size();
            sb.pending.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [aspm_pkg::SAMPLE_W-1:0] rand_sample();
        return aspm_pkg::SAMPLE_W'($urandom_range(65535));
    endfunction

    function automatic logic signed [aspm_pkg::SAMPLE_W-1:0] rand_pointer();
        if ($urandom_range(4) == 0)
            return $urandom_range(1)
                ? aspm_pkg::SAMPLE_W'(32767 - int'($urandom_range(20)))
                : aspm_pkg::SAMPLE_W'(-32768 + int'($urandom_range(20)));
        return rand_sample();
    endfunction

    task automatic send_random(int count);
        int kind;
        int dz;
        int reach;
        longint major;
        longint minor;
        logic signed [aspm_pkg::SAMPLE_W-1:0] sx;
        logic signed [aspm_pkg::SAMPLE_W-1:0] sy;
        repeat (count) begin
            kind = $urandom_range(99);
            dz   = sb.dead_zone;
            if (kind < 15) begin
                sx = rand_sample();
                sy = rand_sample();
            end else if (kind < 35) begin
                // inside the dead zone
                reach = dz * 7 / 10;
                sx = aspm_pkg::SAMPLE_W'(int'($urandom_range(2 * reach)) - reach);
                sy = aspm_pkg::SAMPLE_W'(int'($urandom_range(2 * reach)) - reach);
            end else begin
                if (kind < 65) begin
                    // just past the edge: slow crawl, steps come from the accumulators
                    major = dz + int'($urandom_range((32767 - dz) / 6 + 1));
                    minor = int'($urandom_range(dz / 8 + 2)) - (dz / 16 + 1);
                end else begin
                    major = $urandom_range(32767, 16384);
                    minor = rand_sample();
                end
                if ($urandom_range(1)) major = -major;
                major = motion_scoreboard::clamp(major, -32768, 32767);
                minor = motion_scoreboard::clamp(minor, -32768, 32767);
                if ($urandom_range(1)) begin
                    sx = aspm_pkg::SAMPLE_W'(major);
                    sy = aspm_pkg::SAMPLE_W'(minor);
                end else begin
                    sx = aspm_pkg::SAMPLE_W'(minor);
                    sy = aspm_pkg::SAMPLE_W'(major);
                end
            end
            send_item(sx, sy, rand_pointer(), rand_pointer());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset dead zone: corners, exact edge, just inside, pointer clipping
        send_item(-32768, -32768, -32768, -32768);
        send_item(32767, 32767, 32767, 32767);
        send_item(32767, -32768, 0, 0);
        send_item(-32768, 32767, -1, 1);
        send_item(3000, 0, 100, -100);
        send_item(2999, 0, 100, -100);
        send_item(0, -3000, 0, 0);
        send_item(2121, 2121, 0, 0);
        send_item(100, -100, 0, 0);
        send_item(32767, 0, 32760, -32760);
        send_item(0, -32768, 5, -32765);
        send_random(500);
        wait_drained();
        check_dead_zone_readback();

        // register index 1 does not exist, write must be dropped
        apb_write(ADDR_SPARE, 32'h0000_0005);
        check_dead_zone_readback();
        apb_write(ADDR_DEAD_ZONE, 32'd0);
        check_dead_zone_readback();
        @(posedge aclk);
        send_item(0, 0, 0, 0);              // zero magnitude
        send_item(1, 0, 0, 0);
        send_item(0, -1, 0, 0);
        send_item(-1, -1, 0, 0);
        send_item(32767, 32767, -32768, 32767);
        send_random(400);
        wait_drained();

        send_idle_pct = 64;
        recv_idle_pct = 10;
        // upper pwdata bits must be dropped, leaving the largest dead zone
        apb_write(ADDR_DEAD_ZONE, 32'hFFFF_FFFF);
        check_dead_zone_readback();
        @(posedge aclk);
        send_item(-32768, -32768, 0, 0);    // step far beyond the step range
        send_item(32767, 32767, 32767, 32767);
        send_item(32767, 0, 0, 0);
        send_item(-32768, 32767, -32768, 0);
        send_random(300);
        wait_drained();

        apb_write(ADDR_DEAD_ZONE, aspm_pkg::PDATA_W'($urandom_range(20000, 1)));
        check_dead_zone_readback();
        @(posedge aclk);
        send_random(400);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apb_write(ADDR_DEAD_ZONE, 32'd16000);
        check_dead_zone_readback();
        @(posedge aclk);
        send_random(400);
        wait_drained();

        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
